>>> src/dfe_pkg.sv
// Package for the delimited field extractor: sizes, phase and register codes.
// Uses nothing else; imported by delimited_field_extractor.
package dfe_pkg;

  // Depth of one field buffer bank and the widths that follow from it.
  localparam int FIELD_BYTES = 32;
  localparam int IDX_W       = (FIELD_BYTES > 1) ? $clog2(FIELD_BYTES) : 1;
  localparam int CNT_W       = $clog2(FIELD_BYTES + 1);

  // Fixed field widths.
  localparam int BYTE_W      = 8;
  localparam int MAXC_W      = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  // Byte codes with a special meaning.
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'd0;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;

  // Register reset values.
  localparam logic [BYTE_W-1:0] FIELD_NUMBER_RST = 8'd1;
  localparam logic [BYTE_W-1:0] DELIMITER_RST    = 8'd124;
  localparam logic [MAXC_W-1:0] MAX_CHARS_RST    = 6'd32;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIELD_NUMBER = 2'd0,
    CFG_DELIMITER    = 2'd1,
    CFG_MAX_CHARS    = 2'd2
  } cfg_reg_t;

  // Progress of the copy within one record.
  typedef enum logic [1:0] {
    PHASE_WAIT = 2'd0,
    PHASE_COPY = 2'd1,
    PHASE_DONE = 2'd2
  } phase_t;

  // A byte that ends a record.
  function automatic logic is_record_end(input logic [BYTE_W-1:0] b);
    return (b == CH_NUL) || (b == CH_CR);
  endfunction

  // A byte removed from the tail of a field.
  function automatic logic is_blank(input logic [BYTE_W-1:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  endfunction

endpackage

>>> src/delimited_field_extractor.sv
// Top level of the delimited field extractor: record scanner, two field banks
// and the result sequencer. Depends on dfe_pkg.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_ready  in_record_byte
//   out_     output     out_valid/out_ready out_field_byte, out_byte_valid,
//                                          out_field_found, out_last_item
//   cfg_     input      cfg_we             cfg_index, cfg_wdata
//
// For each record word taken, the scanner updates its counters and
// writes at most one byte into the filling bank. An end-of-record word hands
// that bank to the result sequencer, which sends one result word per cycle while
// out_ready is high (the trimmed length, or one word for empty or missing field).
// Two banks let the next record be scanned while results drain; an end-of-record
// word waits only if the previous record's results are not yet all taken.
// Reset is synchronous and active low and clears all control state and the
// registers to their defaults; the banks are not cleared.
module delimited_field_extractor (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dfe_pkg::BYTE_W-1:0]  in_record_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dfe_pkg::BYTE_W-1:0]  out_field_byte,
  output logic                        out_byte_valid,
  output logic                        out_field_found,
  output logic                        out_last_item,
  input  logic                        cfg_we,
  input  logic [dfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dfe_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import dfe_pkg::*;

  // Configuration registers.
  logic [BYTE_W-1:0] field_number_r;
  logic [BYTE_W-1:0] delimiter_r;
  logic [MAXC_W-1:0] max_chars_r;

  // Per-record scan state.
  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  kept_count_r, kept_count_nxt;
  logic [CNT_W-1:0]  trim_len_r, trim_len_nxt;
  logic [BYTE_W-1:0] delim_count_r, delim_count_nxt;
  logic              any_delim_r, any_delim_nxt;
  logic              at_start_r, at_start_nxt;
  logic              wr_bank_r;

  // Field banks.
  logic [BYTE_W-1:0] bank0_r [FIELD_BYTES];
  logic [BYTE_W-1:0] bank1_r [FIELD_BYTES];
  logic              store_we;

  // Result sequencer state.
  logic              busy_r;
  logic              rd_bank_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic [CNT_W-1:0]  job_len_r;
  logic              job_found_r;
  logic              job_empty_r;

  logic              in_fire, out_fire, rec_end, seq_last;
  logic [CNT_W-1:0]  limit;
  logic [BYTE_W-1:0] rd_byte;
  logic              found_now;

  assign rec_end  = is_record_end(in_record_byte);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign seq_last = job_empty_r || ((CNT_W'(rd_idx_r) + CNT_W'(1)) == job_len_r);

  // An end-of-record word needs the sequencer free, or freeing in this cycle.
  assign in_ready = !rec_end || !busy_r || (out_fire && seq_last);

  // Byte limit: max_chars saturated at the bank depth.
  assign limit = (MAXC_W'(FIELD_BYTES) < max_chars_r) ? CNT_W'(FIELD_BYTES)
                                                      : CNT_W'(max_chars_r);

  assign found_now = (phase_r != PHASE_WAIT) && any_delim_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_number_r <= FIELD_NUMBER_RST;
      delimiter_r    <= DELIMITER_RST;
      max_chars_r    <= MAX_CHARS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIELD_NUMBER: field_number_r <= BYTE_W'(cfg_wdata);
        CFG_DELIMITER:    delimiter_r    <= BYTE_W'(cfg_wdata);
        CFG_MAX_CHARS:    max_chars_r    <= cfg_wdata[MAXC_W-1:0];
        default:          ;
      endcase
    end
  end

  // Next scan state for one record word. The trimmed length follows the
  // position just after the last non-blank byte kept.
  always_comb begin
    phase_t phase_eff;
    phase_nxt       = phase_r;
    kept_count_nxt  = kept_count_r;
    trim_len_nxt    = trim_len_r;
    delim_count_nxt = delim_count_r;
    any_delim_nxt   = any_delim_r;
    at_start_nxt    = 1'b0;
    store_we        = 1'b0;
    phase_eff       = phase_r;
    if (rec_end) begin
      phase_nxt       = PHASE_WAIT;
      kept_count_nxt  = '0;
      trim_len_nxt    = '0;
      delim_count_nxt = '0;
      any_delim_nxt   = 1'b0;
      at_start_nxt    = 1'b1;
    end else if (in_record_byte == delimiter_r) begin
      any_delim_nxt = 1'b1;
      if (delim_count_r != '1) begin
        delim_count_nxt = delim_count_r + BYTE_W'(1);
      end
      if (phase_r == PHASE_COPY) begin
        phase_nxt = PHASE_DONE;
      end else if (phase_r == PHASE_WAIT && field_number_r > BYTE_W'(1) &&
                   delim_count_nxt == field_number_r - BYTE_W'(1)) begin
        phase_nxt = PHASE_COPY;
      end
    end else begin
      if (phase_r == PHASE_WAIT && at_start_r && field_number_r == BYTE_W'(1)) begin
        phase_eff = PHASE_COPY;
      end
      phase_nxt = phase_eff;
      if (phase_eff == PHASE_COPY) begin
        if (kept_count_r < limit) begin
          store_we       = 1'b1;
          kept_count_nxt = kept_count_r + CNT_W'(1);
          if (!is_blank(in_record_byte)) begin
            trim_len_nxt = kept_count_r + CNT_W'(1);
          end
        end else begin
          phase_nxt = PHASE_DONE;
        end
      end
    end
  end

  // Scan state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PHASE_WAIT;
      kept_count_r  <= '0;
      trim_len_r    <= '0;
      delim_count_r <= '0;
      any_delim_r   <= 1'b0;
      at_start_r    <= 1'b1;
      wr_bank_r     <= 1'b0;
    end else if (in_fire) begin
      phase_r       <= phase_nxt;
      kept_count_r  <= kept_count_nxt;
      trim_len_r    <= trim_len_nxt;
      delim_count_r <= delim_count_nxt;
      any_delim_r   <= any_delim_nxt;
      at_start_r    <= at_start_nxt;
      if (rec_end) begin
        wr_bank_r <= !wr_bank_r;
      end
    end
  end

  // Bank writes: at most one kept byte per accepted word into the filling bank.
  always_ff @(posedge clk) begin
    if (in_fire && store_we) begin
      if (wr_bank_r) begin
        bank1_r[kept_count_r[IDX_W-1:0]] <= in_record_byte;
      end else begin
        bank0_r[kept_count_r[IDX_W-1:0]] <= in_record_byte;
      end
    end
  end

  // Result sequencer: loads a job at end of record, steps on each result taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      rd_bank_r   <= 1'b0;
      rd_idx_r    <= '0;
      job_len_r   <= '0;
      job_found_r <= 1'b0;
      job_empty_r <= 1'b1;
    end else if (in_fire && rec_end) begin
      busy_r      <= 1'b1;
      rd_bank_r   <= wr_bank_r;
      rd_idx_r    <= '0;
      job_len_r   <= trim_len_r;
      job_found_r <= found_now;
      job_empty_r <= !(found_now && (trim_len_r != '0));
    end else if (out_fire) begin
      if (seq_last) begin
        busy_r <= 1'b0;
      end else begin
        rd_idx_r <= rd_idx_r + IDX_W'(1);
      end
    end
  end

  // Result word.
  assign rd_byte         = rd_bank_r ? bank1_r[rd_idx_r] : bank0_r[rd_idx_r];
  assign out_valid       = busy_r;
  assign out_field_byte  = job_empty_r ? '0 : rd_byte;
  assign out_byte_valid  = !job_empty_r;
  assign out_field_found = job_found_r;
  assign out_last_item   = seq_last;

  // A data-carrying result always belongs to a found field.
  a_byte_implies_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid |-> out_field_found)
    else $error("byte result without found field");

  // An empty or not-found result is always the single last word.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_last_item)
    else $error("empty result not marked last");

  // A new record may only close once the previous results are finishing.
  a_no_job_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && rec_end && busy_r |-> out_ready && out_last_item)
    else $error("record closed while results still pending");

  // Kept bytes never exceed the bank depth, and the trim stays within them.
  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (kept_count_r <= CNT_W'(FIELD_BYTES)) && (trim_len_r <= kept_count_r))
    else $error("field counters out of range");

endmodule
